/* rtl/core/rc4d_pkg.sv */
package rc4d_pkg;

  localparam int TABLE_SIZE    = 256;
  localparam int IDX_W         = 8;
  localparam int KEY_DEPTH_DEF = 256;
  localparam int DROP_W        = 16;

  localparam logic [DROP_W-1:0] DROP_RESET = 16'd768;

  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_NO_KEY = 1'b1;

  typedef logic [IDX_W-1:0] byte_t;

  // operands of the shared index adder
  typedef struct packed {
    byte_t a;
    byte_t b;
    byte_t c;
  } alu_op_t;

  typedef struct packed {
    byte_t data;
    logic  status;
  } res_t;

endpackage

/* rtl/core/rc4d_ram.sv */
module rc4d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/rc4d_alu.sv */
module rc4d_alu
  import rc4d_pkg::*;
(
  input  alu_op_t op,
  output byte_t   sum
);

  // modulo-256 index sum, shared by every j, t and i step
  assign sum = op.a + op.b + op.c;

endmodule

/* rtl/core/rc4d_seq.sv */
module rc4d_seq
  import rc4d_pkg::*;
#(
  parameter int KEY_DEPTH = KEY_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  byte_t             in_byte,
  input  logic              in_last,
  input  logic [DROP_W-1:0] drop_count,
  output logic              res_valid,
  output res_t              res,
  input  logic              res_take
);

  localparam int KLEN_W = $clog2(KEY_DEPTH + 1);
  localparam int KA_W   = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam byte_t LAST_IDX = IDX_W'(TABLE_SIZE - 1);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_INIT  = 9'b000000010,
    ST_KS_J  = 9'b000000100,
    ST_KS_WJ = 9'b000001000,
    ST_KS_WN = 9'b000010000,
    ST_P_J   = 9'b000100000,
    ST_P_WJ  = 9'b001000000,
    ST_P_WI  = 9'b010000000,
    ST_EMIT  = 9'b100000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [KLEN_W-1:0]   key_len_r, key_len_nxt;
  logic                keyed_r, keyed_nxt;
  logic                data_mode_r, data_mode_nxt;
  logic [DROP_W-1:0]   drop_left_r, drop_left_nxt;
  byte_t               i_r, i_nxt;
  byte_t               j_r, j_nxt;
  byte_t               n_r, n_nxt;
  logic [KA_W-1:0]     k_r, k_nxt;
  byte_t               si_r, si_nxt;
  byte_t               sj_r, sj_nxt;
  byte_t               t_r, t_nxt;
  byte_t               din_r, din_nxt;
  res_t                res_r, res_nxt;

  logic                p_we;
  byte_t               p_waddr, p_wdata, p_raddr, p_rdata;
  logic                k_we;
  logic [KA_W-1:0]     k_waddr, k_raddr;
  byte_t               k_wdata, k_rdata;

  alu_op_t             alu_op;
  byte_t               alu_sum;

  logic                accept;
  logic                key_full;
  logic [KLEN_W-1:0]   k_inc;
  logic [KA_W-1:0]     k_next;
  byte_t               n_inc;
  byte_t               ks;

  rc4d_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_SIZE)) u_perm (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  rc4d_ram #(.WIDTH(IDX_W), .DEPTH(KEY_DEPTH)) u_key (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (k_wdata),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  rc4d_alu u_alu (
    .op  (alu_op),
    .sum (alu_sum)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign key_full  = (key_len_r >= KLEN_W'(KEY_DEPTH));
  assign k_inc     = KLEN_W'(k_r) + KLEN_W'(1);
  assign k_next    = (k_inc >= key_len_r) ? '0 : k_inc[KA_W-1:0];
  assign n_inc     = n_r + 8'd1;
  assign res       = res_r;

  // the swap has not reached the table when t was read, so take those two from registers
  assign ks = (t_r == i_r) ? sj_r :
              (t_r == j_r) ? si_r : p_rdata;

  always_comb begin
    state_nxt     = state_r;
    key_len_nxt   = key_len_r;
    keyed_nxt     = keyed_r;
    data_mode_nxt = data_mode_r;
    drop_left_nxt = drop_left_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    t_nxt         = t_r;
    din_nxt       = din_r;
    res_nxt       = res_r;
    p_we          = 1'b0;
    p_waddr       = n_r;
    p_wdata       = n_r;
    p_raddr       = i_r;
    k_we          = 1'b0;
    k_waddr       = key_len_r[KA_W-1:0];
    k_wdata       = in_byte;
    k_raddr       = k_r;
    alu_op        = '{a: i_r, b: 8'd1, c: '0};
    res_valid     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_KEY) begin
            if (!key_full) begin
              k_we        = 1'b1;
              key_len_nxt = key_len_r + KLEN_W'(1);
            end
            if (in_last) begin
              n_nxt     = '0;
              state_nxt = ST_INIT;
            end
          end else if (!keyed_r) begin
            res_nxt   = '{data: '0, status: STATUS_NO_KEY};
            state_nxt = ST_EMIT;
          end else begin
            p_raddr       = alu_sum;
            i_nxt         = alu_sum;
            din_nxt       = in_byte;
            data_mode_nxt = 1'b1;
            state_nxt     = ST_P_J;
          end
        end
      end

      ST_INIT: begin
        p_we    = 1'b1;
        p_waddr = n_r;
        p_wdata = n_r;
        if (n_r == LAST_IDX) begin
          n_nxt     = '0;
          k_nxt     = '0;
          j_nxt     = '0;
          p_raddr   = '0;
          k_raddr   = '0;
          state_nxt = ST_KS_J;
        end else begin
          n_nxt = n_inc;
        end
      end

      ST_KS_J: begin
        alu_op    = '{a: j_r, b: k_rdata, c: p_rdata};
        j_nxt     = alu_sum;
        p_raddr   = alu_sum;
        si_nxt    = p_rdata;
        state_nxt = ST_KS_WJ;
      end

      ST_KS_WJ: begin
        p_we      = 1'b1;
        p_waddr   = j_r;
        p_wdata   = si_r;
        sj_nxt    = p_rdata;
        state_nxt = ST_KS_WN;
      end

      ST_KS_WN: begin
        p_we    = 1'b1;
        p_waddr = n_r;
        p_wdata = sj_r;
        if (n_r == LAST_IDX) begin
          key_len_nxt   = '0;
          keyed_nxt     = 1'b1;
          j_nxt         = '0;
          data_mode_nxt = 1'b0;
          if (drop_count == '0) begin
            i_nxt     = '0;
            state_nxt = ST_IDLE;
          end else begin
            i_nxt         = 8'd1;
            p_raddr       = 8'd1;
            drop_left_nxt = drop_count;
            state_nxt     = ST_P_J;
          end
        end else begin
          n_nxt     = n_inc;
          k_nxt     = k_next;
          p_raddr   = n_inc;
          k_raddr   = k_next;
          state_nxt = ST_KS_J;
        end
      end

      ST_P_J: begin
        alu_op    = '{a: j_r, b: p_rdata, c: '0};
        j_nxt     = alu_sum;
        p_raddr   = alu_sum;
        si_nxt    = p_rdata;
        state_nxt = ST_P_WJ;
      end

      ST_P_WJ: begin
        p_we      = 1'b1;
        p_waddr   = j_r;
        p_wdata   = si_r;
        sj_nxt    = p_rdata;
        alu_op    = '{a: si_r, b: p_rdata, c: '0};
        p_raddr   = alu_sum;
        t_nxt     = alu_sum;
        state_nxt = ST_P_WI;
      end

      ST_P_WI: begin
        p_we    = 1'b1;
        p_waddr = i_r;
        p_wdata = sj_r;
        if (data_mode_r) begin
          res_nxt   = '{data: din_r ^ ks, status: STATUS_OK};
          state_nxt = ST_EMIT;
        end else if (drop_left_r == DROP_W'(1)) begin
          drop_left_nxt = '0;
          state_nxt     = ST_IDLE;
        end else begin
          // discard run: fetch S[i+1] while S[i] is written back
          drop_left_nxt = drop_left_r - DROP_W'(1);
          p_raddr       = alu_sum;
          i_nxt         = alu_sum;
          state_nxt     = ST_P_J;
        end
      end

      ST_EMIT: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      key_len_r   <= '0;
      keyed_r     <= 1'b0;
      data_mode_r <= 1'b0;
      drop_left_r <= '0;
      i_r         <= '0;
      j_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      key_len_r   <= key_len_nxt;
      keyed_r     <= keyed_nxt;
      data_mode_r <= data_mode_nxt;
      drop_left_r <= drop_left_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    k_r   <= k_nxt;
    si_r  <= si_nxt;
    sj_r  <= sj_nxt;
    t_r   <= t_nxt;
    din_r <= din_nxt;
    res_r <= res_nxt;
  end

endmodule

/* rtl/core/rc4_drop_stream_cipher.sv */
// RC4-drop stream cipher, one byte per beat.
// Input channel (in_valid/in_ready): in_cmd 0 carries a key byte, in_cmd 1 a data byte.
// A key byte with in_last_key high closes the key and starts the key schedule.
// Output channel (out_valid/out_ready): one beat per data byte, none per key byte;
// out_data_out is the data byte xor keystream, out_status flags a data byte seen
// before any key (data then reads zero).
// cfg_we/cfg_wdata set how many keystream bytes are thrown away after each schedule;
// write it only while the block is idle.
// Flow: a key byte is taken while the block stays idle. The closing key byte holds
// in_ready low while the table is filled, the key schedule runs its read, write-j and
// write-n states for each index, and each discarded byte runs its j read, write-j and
// write-i states, all bound by the single port pair of the table ram. A data byte
// runs the j read, write-j, write-i and result states, and no new byte is taken until
// the result state hands its result to the output register, which drives the output.
// The output register lets the next beat be accepted while a result waits; a stall
// on out_ready holds the block in its result cycle only once a second result is ready.
// Reset drops the key, clears i, j and out_valid, and sets the discard count to 768.
module rc4_drop_stream_cipher
  import rc4d_pkg::*;
#(
  parameter int KEY_DEPTH = KEY_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [7:0]        in_byte_value,
  input  logic              in_last_key,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_data_out,
  output logic              out_status,
  input  logic              cfg_we,
  input  logic [DROP_W-1:0] cfg_wdata
);

  logic [DROP_W-1:0] drop_count_r;
  logic              out_valid_r;
  byte_t             out_data_r;
  logic              out_status_r;
  logic              res_valid;
  res_t              res;
  logic              res_take;

  rc4d_seq #(.KEY_DEPTH(KEY_DEPTH)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_byte    (in_byte_value),
    .in_last    (in_last_key),
    .drop_count (drop_count_r),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (res_take)
  );

  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_count_r <= DROP_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        drop_count_r <= cfg_wdata;
      end
      if (res_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r   <= res.data;
      out_status_r <= res.status;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_status   = out_status_r;

endmodule
